### sv/heartbeat_producer_consumer_macros.svh
// assertion macros for the heartbeat producer and consumer
`ifndef HEARTBEAT_PRODUCER_CONSUMER_MACROS_SVH
`define HEARTBEAT_PRODUCER_CONSUMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HBPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hbpc_pkg.sv
// shared types and constants for the heartbeat producer and consumer
package hbpc_pkg;

  localparam int WatchEntries = 4;

  localparam int NodeIdW   = 7;
  localparam int PeriodW   = 16;
  localparam int IdsW      = 32;
  localparam int CyclesW   = 64;
  localparam int EntryIdW  = 8;
  localparam int CycleW    = 16;
  localparam int ElapsedW  = 17;
  localparam int StateW    = 8;
  localparam int FrameIdW  = 11;
  localparam int LenW      = 4;
  localparam int DataW     = 64;
  localparam int AddrW     = 5;

  localparam logic [NodeIdW-1:0] NodeIdReset = 7'd1;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd1000;
  localparam logic [StateW-1:0]  StateStopped = 8'd4;

  // heartbeat base id 0x700 seen through the upper id bits
  localparam logic [FrameIdW-NodeIdW-1:0] HbBaseHi = 4'hE;
  localparam logic [LenW-1:0] HbLength = 4'd1;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindFrame = 2'd1,
    KindQuery = 2'd2,
    KindNop   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RegOwnNodeId   = 2'd0,
    RegPeriod      = 2'd1,
    RegWatchedIds  = 2'd2,
    RegWatchedTime = 2'd3
  } reg_e;

endpackage

### sv/heartbeat_producer_consumer.sv
// heartbeat producer and consumer: tick countdown, watched node timers, queries
// the result passes through the input register and then the result register
// throughput: one item per cycle while the output is not stalled, one result per item
// the countdown and timers update when an item moves into the result register
// reset: config to defaults, countdown to 1000, timers to zero, states to stopped
`include "heartbeat_producer_consumer_macros.svh"

module heartbeat_producer_consumer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hbpc_pkg::AddrW-1:0]       paddr,
  input  logic [hbpc_pkg::DataW-1:0]       pwdata,
  output logic [hbpc_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       kind_i,
  input  logic [hbpc_pkg::PeriodW-1:0]     step_ms_i,
  input  logic [hbpc_pkg::StateW-1:0]      nmt_state_i,
  input  logic                             frame_standard_i,
  input  logic [hbpc_pkg::FrameIdW-1:0]    frame_id_i,
  input  logic [hbpc_pkg::LenW-1:0]        frame_length_i,
  input  logic [hbpc_pkg::StateW-1:0]      frame_byte0_i,
  input  logic [hbpc_pkg::EntryIdW-1:0]    query_node_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             send_valid_o,
  output logic [hbpc_pkg::FrameIdW-1:0]    send_id_o,
  output logic [hbpc_pkg::StateW-1:0]      send_state_o,
  output logic                             query_expired_o,
  output logic [hbpc_pkg::StateW-1:0]      query_state_o
);

  localparam int N = hbpc_pkg::WatchEntries;

  // configuration registers
  logic [hbpc_pkg::NodeIdW-1:0]  own_id_q;
  logic [hbpc_pkg::PeriodW-1:0]  period_q;
  logic [hbpc_pkg::IdsW-1:0]     ids_q;
  logic [hbpc_pkg::CyclesW-1:0]  cycles_q;
  logic                          cfg_wr;
  hbpc_pkg::reg_e                cfg_reg;

  // input register
  logic                          in_valid_q;
  hbpc_pkg::kind_e               kind_q;
  logic [hbpc_pkg::PeriodW-1:0]  step_q;
  logic [hbpc_pkg::StateW-1:0]   nmt_q;
  logic                          fstd_q;
  logic [hbpc_pkg::FrameIdW-1:0] fid_q;
  logic [hbpc_pkg::LenW-1:0]     flen_q;
  logic [hbpc_pkg::StateW-1:0]   fb0_q;
  logic [hbpc_pkg::EntryIdW-1:0] qnode_q;

  // block state
  logic [hbpc_pkg::PeriodW-1:0]  countdown_q, countdown_d;
  logic [hbpc_pkg::ElapsedW-1:0] elapsed_q [N];
  logic [hbpc_pkg::ElapsedW-1:0] elapsed_d [N];
  logic [hbpc_pkg::StateW-1:0]   wstate_q [N];
  logic [hbpc_pkg::StateW-1:0]   wstate_d [N];

  // result register
  logic                          out_valid_q;
  logic                          send_valid_q, send_valid_d;
  logic [hbpc_pkg::FrameIdW-1:0] send_id_q, send_id_d;
  logic [hbpc_pkg::StateW-1:0]   send_state_q, send_state_d;
  logic                          qexp_q, qexp_d;
  logic [hbpc_pkg::StateW-1:0]   qstate_q, qstate_d;

  logic                          advance;
  logic                          in_take;
  logic                          fire;
  logic                          frame_ok;
  logic [hbpc_pkg::EntryIdW-1:0] frame_node;
  logic [N-1:0]                  frame_hit;
  logic [N-1:0]                  query_hit;
  logic                          query_found;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_reg = hbpc_pkg::reg_e'(paddr[hbpc_pkg::AddrW-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= hbpc_pkg::NodeIdReset;
      period_q <= hbpc_pkg::PeriodReset;
      ids_q    <= '0;
      cycles_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        hbpc_pkg::RegOwnNodeId:   own_id_q <= pwdata[hbpc_pkg::NodeIdW-1:0];
        hbpc_pkg::RegPeriod:      period_q <= pwdata[hbpc_pkg::PeriodW-1:0];
        hbpc_pkg::RegWatchedIds:  ids_q    <= pwdata[hbpc_pkg::IdsW-1:0];
        hbpc_pkg::RegWatchedTime: cycles_q <= pwdata[hbpc_pkg::CyclesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_reg)
      hbpc_pkg::RegOwnNodeId:   prdata = hbpc_pkg::DataW'(own_id_q);
      hbpc_pkg::RegPeriod:      prdata = hbpc_pkg::DataW'(period_q);
      hbpc_pkg::RegWatchedIds:  prdata = hbpc_pkg::DataW'(ids_q);
      hbpc_pkg::RegWatchedTime: prdata = cycles_q;
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ handshake
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= hbpc_pkg::kind_e'(kind_i);
      step_q  <= step_ms_i;
      nmt_q   <= nmt_state_i;
      fstd_q  <= frame_standard_i;
      fid_q   <= frame_id_i;
      flen_q  <= frame_length_i;
      fb0_q   <= frame_byte0_i;
      qnode_q <= query_node_i;
    end
  end

  // ------------------------------------------------------------ processing
  assign fire       = step_q >= countdown_q;
  assign frame_ok   = fstd_q && (fid_q[hbpc_pkg::FrameIdW-1:hbpc_pkg::NodeIdW] ==
                      hbpc_pkg::HbBaseHi) && (flen_q == hbpc_pkg::HbLength);
  assign frame_node = {1'b0, fid_q[hbpc_pkg::NodeIdW-1:0]};

  // first matching entry wins, as a one-hot vector
  always_comb begin
    logic ff;
    logic qf;
    ff = 1'b0;
    qf = 1'b0;
    for (int i = 0; i < N; i++) begin
      frame_hit[i] = !ff && (ids_q[i*hbpc_pkg::EntryIdW +: hbpc_pkg::EntryIdW] == frame_node);
      query_hit[i] = !qf && (ids_q[i*hbpc_pkg::EntryIdW +: hbpc_pkg::EntryIdW] == qnode_q);
      ff = ff || frame_hit[i];
      qf = qf || query_hit[i];
    end
    query_found = qf;
  end

  always_comb begin
    logic                          exp_or;
    logic [hbpc_pkg::StateW-1:0]   st_or;
    logic [hbpc_pkg::ElapsedW-1:0] cyc;
    countdown_d  = countdown_q;
    send_valid_d = 1'b0;
    send_id_d    = '0;
    send_state_d = '0;
    qexp_d       = 1'b0;
    qstate_d     = '0;
    exp_or       = 1'b0;
    st_or        = '0;
    cyc          = '0;
    for (int i = 0; i < N; i++) begin
      elapsed_d[i] = elapsed_q[i];
      wstate_d[i]  = wstate_q[i];
    end
    unique case (kind_q)
      hbpc_pkg::KindTick: begin
        if (fire) begin
          countdown_d  = period_q;
          send_valid_d = 1'b1;
          send_id_d    = {hbpc_pkg::HbBaseHi, own_id_q};
          send_state_d = nmt_q;
        end else begin
          countdown_d = countdown_q - step_q;
        end
        for (int i = 0; i < N; i++) begin
          cyc = hbpc_pkg::ElapsedW'(cycles_q[i*hbpc_pkg::CycleW +: hbpc_pkg::CycleW]);
          if (elapsed_q[i] < cyc) begin
            elapsed_d[i] = elapsed_q[i] + hbpc_pkg::ElapsedW'(step_q);
          end
        end
      end
      hbpc_pkg::KindFrame: begin
        for (int i = 0; i < N; i++) begin
          if (frame_ok && frame_hit[i]) begin
            elapsed_d[i] = '0;
            wstate_d[i]  = fb0_q;
          end
        end
      end
      hbpc_pkg::KindQuery: begin
        for (int i = 0; i < N; i++) begin
          cyc = hbpc_pkg::ElapsedW'(cycles_q[i*hbpc_pkg::CycleW +: hbpc_pkg::CycleW]);
          exp_or = exp_or || (query_hit[i] && (elapsed_q[i] >= cyc));
          st_or  = st_or | (query_hit[i] ? wstate_q[i] : '0);
        end
        qexp_d   = exp_or;
        qstate_d = query_found ? st_or : hbpc_pkg::StateStopped;
      end
      hbpc_pkg::KindNop: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= hbpc_pkg::PeriodReset;
      for (int i = 0; i < N; i++) begin
        elapsed_q[i] <= '0;
        wstate_q[i]  <= hbpc_pkg::StateStopped;
      end
    end else if (advance) begin
      countdown_q <= countdown_d;
      for (int i = 0; i < N; i++) begin
        elapsed_q[i] <= elapsed_d[i];
        wstate_q[i]  <= wstate_d[i];
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      send_valid_q <= send_valid_d;
      send_id_q    <= send_id_d;
      send_state_q <= send_state_d;
      qexp_q       <= qexp_d;
      qstate_q     <= qstate_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = send_valid_q;
  assign send_id_o       = send_id_q;
  assign send_state_o    = send_state_q;
  assign query_expired_o = qexp_q;
  assign query_state_o   = qstate_q;

  // ------------------------------------------------------------ assertions
  `HBPC_ASSERT_NOW(a_no_stall_when_empty, !in_valid_q, !in_stall_o,
    "input stalled with empty input register")
  `HBPC_ASSERT_NOW(a_send_id_base, out_valid_o && send_valid_o,
    send_id_o[hbpc_pkg::FrameIdW-1:hbpc_pkg::NodeIdW] == hbpc_pkg::HbBaseHi,
    "heartbeat id outside base range")
  `HBPC_ASSERT_NOW(a_send_excludes_query, out_valid_o && send_valid_o,
    !query_expired_o && (query_state_o == '0), "heartbeat result carries query fields")
  `HBPC_ASSERT_NEXT(a_fire_reloads, advance && (kind_q == hbpc_pkg::KindTick) && fire,
    countdown_q == $past(period_q), "countdown not reloaded after heartbeat")
  `HBPC_ASSERT_NEXT(a_frame_clears_timer,
    advance && (kind_q == hbpc_pkg::KindFrame) && frame_ok && frame_hit[0],
    elapsed_q[0] == '0, "matching frame did not clear entry timer")

endmodule
